@@ src/sorted_set_table_top_macros.svh @@
// Assertion macros for the sorted set table RTL.
`ifndef SORTED_SET_TABLE_TOP_MACROS_SVH
`define SORTED_SET_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sorted set table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sorted set table assertion failed");

`endif

@@ src/sst_pkg.sv @@
// Types and constants for the sorted set table.
package sst_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_LOOKUP = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [5:0]  position;
    } sst_in_t;

    typedef struct packed {
        logic        hit;
        logic [5:0]  where_index;
        logic [31:0] read_value;
        logic [6:0]  entry_count;
        logic [31:0] min_value;
        logic [31:0] max_value;
        logic [1:0]  status;
    } sst_out_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic        cmp;
        logic        ins;
        logic        del;
        logic [31:0] key;
    } sst_ctrl_t;

endpackage

@@ src/sorted_set_table_top.sv @@
// Sorted set table: a chain of compare-and-shift cells with its controller.
//
//   port group   direction   payload      transfer when
//   s_*          in          sst_in_t     s_valid && s_ready
//   m_*          out         sst_out_t    m_valid && m_ready
//
// Each operation goes from input transfer to a loaded result in three steps: the transfer
// edge compares in all cells, the edge leaving S_UPD shifts/updates, and the S_FIN edge
// captures the result once the output slot is free. That capture also takes the next
// operation; no operation is taken while one is in S_UPD.
// Reset (aresetn low, synchronous) empties the set; cell contents are not cleared.
// A result held on m_* stalls capture, and the input waits until the slot frees.
module sorted_set_table_top #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sst_pkg::sst_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sst_pkg::sst_out_t m_data
);
    import sst_pkg::*;

    `include "sorted_set_table_top_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [1:0] {S_IDLE, S_UPD, S_FIN} state_t;

    state_t        state_reg;
    sst_in_t       op_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          hit_reg;
    logic [5:0]    where_reg;
    logic [31:0]   rd_reg;
    logic [1:0]    status_reg;
    logic          m_valid_reg;
    sst_out_t      m_data_reg;

    logic [31:0]       cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_ge;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] ge_prev;
    logic [CAPACITY-1:0] ge_edge;
    logic [CAPACITY-1:0] cell_last;
    logic [CAPACITY:0]   valid_ext;
    sst_ctrl_t           ctrl;

    logic          out_free;
    logic          accept;
    logic          is_search;
    logic          hit_w;
    logic          any_edge;
    logic [IW-1:0] edge_idx;
    logic [CW-1:0] lb_w;
    logic [5:0]    where_w;
    logic [31:0]   rd_sel;
    logic          pos_ok;
    logic [31:0]   min_w;
    logic [31:0]   max_w;
    logic          full_w;
    logic          do_ins;
    logic          do_del;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = aresetn
                      && ((state_reg == S_IDLE) || ((state_reg == S_FIN) && out_free));
    assign accept   = s_valid && s_ready;

    assign is_search = op_reg.kind inside {KIND_ADD, KIND_REMOVE, KIND_LOOKUP};
    assign hit_w     = |(cell_eq & cell_valid);
    assign full_w    = (count_reg == CW'(CAPACITY));
    assign do_ins    = (state_reg == S_UPD) && (op_reg.kind == KIND_ADD) && !hit_w && !full_w;
    assign do_del    = (state_reg == S_UPD) && (op_reg.kind == KIND_REMOVE) && hit_w;

    always_comb begin
        ctrl.cmp = accept;
        ctrl.ins = do_ins;
        ctrl.del = do_del;
        ctrl.key = accept ? s_data.value : op_reg.value;
    end

    assign ge_prev   = {cell_ge[CAPACITY-2:0], 1'b0};
    assign ge_edge   = cell_ge & ~ge_prev;
    assign valid_ext = {1'b0, cell_valid};
    assign cell_last = cell_valid & ~valid_ext[CAPACITY:1];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [31:0] left_value;
            logic [31:0] right_value;

            assign cell_valid[g] = (CW'(g) < count_reg);

            if (g == 0) begin : g_first
                assign left_value = '0;
            end else begin : g_mid
                assign left_value = cell_value[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign right_value = cell_value[g];
            end else begin : g_body
                assign right_value = cell_value[g+1];
            end

            sst_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .cell_valid  (cell_valid[g]),
                .left_ge     (ge_prev[g]),
                .left_value  (left_value),
                .right_value (right_value),
                .value_o     (cell_value[g]),
                .ge_o        (cell_ge[g]),
                .eq_o        (cell_eq[g])
            );
        end
    endgenerate

    // Encode the lower bound and pick out the read and max cells.
    always_comb begin
        edge_idx = '0;
        rd_sel   = '0;
        max_w    = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (ge_edge[i]) begin
                edge_idx = edge_idx | IW'(i);
            end
            if (32'(i) == 32'(op_reg.position)) begin
                rd_sel = rd_sel | cell_value[i];
            end
            if (cell_last[i]) begin
                max_w = max_w | cell_value[i];
            end
        end
    end

    assign any_edge = |ge_edge;
    assign lb_w     = any_edge ? CW'(edge_idx) : CW'(CAPACITY);
    assign where_w  = (32'(lb_w) > 32'd63) ? 6'd63 : 6'(lb_w);
    assign pos_ok   = 32'(op_reg.position) < 32'(count_reg);
    assign min_w    = cell_valid[0] ? cell_value[0] : 32'd0;

    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (do_del) begin
            count_next = count_reg - CW'(1);
        end else if ((state_reg == S_UPD) && (op_reg.kind == KIND_CLEAR)) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            // drop the result once taken, unless a new one is captured this cycle
            if (m_ready && (state_reg != S_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg    <= s_data;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    hit_reg    <= is_search ? hit_w : 1'b0;
                    where_reg  <= is_search ? where_w : 6'd0;
                    rd_reg     <= ((op_reg.kind == KIND_READ) && pos_ok) ? rd_sel : 32'd0;
                    if ((op_reg.kind == KIND_ADD) && !hit_w && full_w) begin
                        status_reg <= ST_FULL;
                    end else if ((op_reg.kind == KIND_READ) && !pos_ok) begin
                        status_reg <= ST_RANGE;
                    end else begin
                        status_reg <= ST_OK;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        // capture the result and take the next operation if one is offered
                        m_valid_reg            <= 1'b1;
                        m_data_reg.hit         <= hit_reg;
                        m_data_reg.where_index <= where_reg;
                        m_data_reg.read_value  <= rd_reg;
                        m_data_reg.entry_count <= 7'(count_reg);
                        m_data_reg.min_value   <= min_w;
                        m_data_reg.max_value   <= max_w;
                        m_data_reg.status      <= status_reg;
                        if (accept) begin
                            op_reg    <= s_data;
                            state_reg <= S_UPD;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SST_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(CAPACITY))
    `SST_ASSERT_NXT(a_accept_upd, aclk, aresetn, accept, state_reg == S_UPD)
    `SST_ASSERT_IMP(a_upd_busy, aclk, aresetn, state_reg == S_UPD, !s_ready)
    `SST_ASSERT_IMP(a_full_count, aclk, aresetn, m_valid && (m_data.status == ST_FULL),
        m_data.entry_count == 7'(CAPACITY))

endmodule

@@ src/sst_cell.sv @@
// One storage cell of the sorted chain: holds a value, compares it, shifts it.
module sst_cell (
    input  logic              aclk,
    input  sst_pkg::sst_ctrl_t ctrl,
    input  logic              cell_valid,
    input  logic              left_ge,
    input  logic [31:0]       left_value,
    input  logic [31:0]       right_value,
    output logic [31:0]       value_o,
    output logic              ge_o,
    output logic              eq_o
);

    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic        ge_reg;
    logic        eq_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.ins && ge_reg) begin
            // first cell at or above the key takes the key, the rest move up
            value_next = left_ge ? left_value : ctrl.key;
        end else if (ctrl.del && ge_reg) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (ctrl.cmp) begin
            // empty cells count as not below the key
            ge_reg <= !cell_valid || !(value_reg < ctrl.key);
            eq_reg <= (value_reg == ctrl.key);
        end
    end

    assign value_o = value_reg;
    assign ge_o    = ge_reg;
    assign eq_o    = eq_reg;

endmodule
